[hdl/stable_sorted_priority_queue_unit_macros.svh]
// ----------------------------------------------------------------------------
// stable sorted priority queue assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
`define SSPQ_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sspq check failed");
`define SSPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sspq check failed");
`else
`define SSPQ_ASSERT(label, clk, rstn, ante, cons)
`define SSPQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hdl/sspq_pkg.sv]
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam int CNT_W = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [7:0] EMPTY_VALUE = 8'd120;

    typedef struct packed {
        logic       command;
        logic [7:0] item_value;
        logic [7:0] priority_req;
    } sspq_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_value;
        logic [CNT_W-1:0] occupancy;
    } sspq_out_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } sspq_ctrl_t;

endpackage

[hdl/sspq_cell.sv]
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry, compares it to the incoming
// priority and takes its own, the new, the left or the right entry.
// ----------------------------------------------------------------------------
module sspq_cell #(
    parameter int PRIO_WIDTH = 8
) (
    input  logic                  aclk,
    input  sspq_pkg::sspq_ctrl_t  ctrl,
    input  logic                  occ,
    input  logic [7:0]            new_value,
    input  logic [PRIO_WIDTH-1:0] new_prio,
    input  logic                  prev_keep,
    input  logic [7:0]            prev_value,
    input  logic [PRIO_WIDTH-1:0] prev_prio,
    input  logic [7:0]            next_value,
    input  logic [PRIO_WIDTH-1:0] next_prio,
    output logic                  keep,
    output logic [7:0]            value,
    output logic [PRIO_WIDTH-1:0] prio
);

    logic [7:0]            value_reg, value_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;

    assign keep  = occ && (prio_reg >= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !keep) begin
            if (prev_keep) begin
                value_next = new_value;
                prio_next  = new_prio;
            end else begin
                value_next = prev_value;
                prio_next  = prev_prio;
            end
        end else if (ctrl.deq) begin
            value_next = next_value;
            prio_next  = next_prio;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

[hdl/stable_sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Each request is held in the input register; the chain update and result follow
// once the output is free, and no new request is taken until then.
// Synchronous active-low reset empties the queue and sets capacity to 16.
// ----------------------------------------------------------------------------
`include "stable_sorted_priority_queue_unit_macros.svh"

module stable_sorted_priority_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  sspq_pkg::sspq_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output sspq_pkg::sspq_out_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sspq_pkg::CNT_W-1:0] cfg_data
);

    localparam int CW = sspq_pkg::CNT_W;

    logic                 busy_reg, busy_next;
    sspq_pkg::sspq_in_t   req_reg, req_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        cap_reg, cap_next;
    logic                 m_valid_reg, m_valid_next;
    sspq_pkg::sspq_out_t  m_data_reg, m_data_next;

    logic                 exec;
    logic                 full;
    logic                 empty;
    logic                 do_enq;
    logic                 do_deq;
    logic [PRIO_WIDTH-1:0] req_prio;
    sspq_pkg::sspq_ctrl_t ctrl;

    logic [7:0]            cell_value [DEPTH];
    logic [PRIO_WIDTH-1:0] cell_prio  [DEPTH];
    logic                  cell_keep  [DEPTH];

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign exec     = busy_reg && (!m_valid_reg || m_ready);
    assign req_prio = PRIO_WIDTH'(req_reg.priority_req);
    assign full     = (cnt_reg >= cap_reg) || (32'(cnt_reg) >= DEPTH);
    assign empty    = (cnt_reg == '0);
    assign do_enq   = exec && (req_reg.command == sspq_pkg::CMD_ENQ) && !full;
    assign do_deq   = exec && (req_reg.command == sspq_pkg::CMD_DEQ) && !empty;
    assign ctrl.enq = do_enq;
    assign ctrl.deq = do_deq;

    // cell chain
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic                  prev_keep;
            logic [7:0]            prev_value;
            logic [PRIO_WIDTH-1:0] prev_prio;
            logic [7:0]            next_value;
            logic [PRIO_WIDTH-1:0] next_prio;
            logic                  occ;

            assign occ = (32'(cnt_reg) > i);

            if (i == 0) begin : g_head
                assign prev_keep  = 1'b1;
                assign prev_value = req_reg.item_value;
                assign prev_prio  = req_prio;
            end else begin : g_body
                assign prev_keep  = cell_keep[i-1];
                assign prev_value = cell_value[i-1];
                assign prev_prio  = cell_prio[i-1];
            end

            if (i == DEPTH - 1) begin : g_tail
                assign next_value = cell_value[i];
                assign next_prio  = cell_prio[i];
            end else begin : g_mid
                assign next_value = cell_value[i+1];
                assign next_prio  = cell_prio[i+1];
            end

            sspq_cell #(
                .PRIO_WIDTH (PRIO_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occ        (occ),
                .new_value  (req_reg.item_value),
                .new_prio   (req_prio),
                .prev_keep  (prev_keep),
                .prev_value (prev_value),
                .prev_prio  (prev_prio),
                .next_value (next_value),
                .next_prio  (next_prio),
                .keep       (cell_keep[i]),
                .value      (cell_value[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    always_comb begin
        busy_next    = busy_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        cap_next     = cap_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (exec) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            m_data_next.status    = sspq_pkg::ST_OK;
            m_data_next.out_value = 8'd0;
            if (req_reg.command == sspq_pkg::CMD_ENQ) begin
                if (full) begin
                    m_data_next.status = sspq_pkg::ST_FULL;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end else begin
                if (empty) begin
                    m_data_next.status    = sspq_pkg::ST_EMPTY;
                    m_data_next.out_value = sspq_pkg::EMPTY_VALUE;
                end else begin
                    m_data_next.out_value = cell_value[0];
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            m_data_next.occupancy = cnt_next;
        end

        if (s_valid && s_ready) begin
            busy_next = 1'b1;
            req_next  = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            cap_reg     <= CW'(16);
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
    end

    `SSPQ_ASSERT(a_cnt_bound, aclk, aresetn, 1'b1, 32'(cnt_reg) <= DEPTH)
    `SSPQ_ASSERT_NEXT(a_enq_cnt, aclk, aresetn, do_enq, cnt_reg == CW'($past(cnt_reg) + CW'(1)))
    `SSPQ_ASSERT(a_sorted, aclk, aresetn, cnt_reg >= CW'(2), cell_prio[0] >= cell_prio[1])
    `SSPQ_ASSERT(a_empty_res, aclk, aresetn, m_valid && (m_data.status == sspq_pkg::ST_EMPTY), (m_data.occupancy == '0) && (m_data.out_value == sspq_pkg::EMPTY_VALUE))

endmodule
